FILE: src/ffa_pkg.sv
// Shared types, constants and cell control codes for the first-fit heap allocator.
// No dependencies.
package ffa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_W     = $clog2(PAGE_BYTES);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_ROT  = 2'd1;
  localparam logic [1:0] OP_INS  = 2'd2;
  localparam logic [1:0] OP_REM  = 2'd3;

  typedef struct packed {
    logic        func;
    logic [24:0] request_size;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_address;
    logic [31:0] heap_top;
  } rsp_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] limit;
  } entry_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [31:0]      run;
    logic [31:0]      new_limit;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] rem_idx;
  } cell_ctl_t;

endpackage

FILE: src/first_fit_heap_block_allocator.sv
// First-fit heap block allocator: sequencer plus a ring of MAX_BLOCKS entry cells.
// Steps from acceptance to response valid: ring rotation scan, three arithmetic steps, shift
// update, output load. No new request is accepted until the last response is loaded.
// Full-table allocate goes straight to output load; unknown-base free skips arithmetic and update.
// A stalled response holds the sequencer. Synchronous reset empties the table, zeroes base/top.
// Depends on ffa_pkg and ffa_cell.
module first_fit_heap_block_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ffa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ffa_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CALC1 = 3'd2;
  localparam logic [2:0] S_CALC2 = 3'd3;
  localparam logic [2:0] S_CALC3 = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [33:0] PAGE_MASK = ~34'(ffa_pkg::PAGE_BYTES - 1);

  logic [2:0]                state;
  logic [ffa_pkg::IDX_W-1:0] k;
  logic                      func;
  logic [24:0]               size;
  logic [31:0]               addr;
  logic [31:0]               run;
  logic                      placed;
  logic                      found;
  logic [ffa_pkg::IDX_W-1:0] fidx;
  logic [31:0]               top;
  logic [32:0]               endv;
  logic [33:0]               grow;
  logic                      grow_en;
  logic [33:0]               calc;
  logic [1:0]                status;
  logic [31:0]               result;
  logic [ffa_pkg::CNT_W-1:0] count;
  logic [31:0]               brk;
  logic [31:0]               heap_base;

  ffa_pkg::entry_t           entries [ffa_pkg::MAX_BLOCKS];
  logic                      les     [ffa_pkg::MAX_BLOCKS];
  ffa_pkg::cell_ctl_t        ctl;
  ffa_pkg::entry_t           head;
  logic                      head_valid;
  logic                      alloc_ok;
  logic [32:0]               excess;
  logic                      rsp_load;

  // a configuration write in idle takes priority, so the request side waits
  assign req_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready  = (state == S_IDLE);
  assign head       = entries[0];
  assign head_valid = ({1'b0, k} < count);
  assign alloc_ok   = !endv[32] && (calc[33:32] == 2'd0);
  assign excess     = endv - {1'b0, brk};
  assign rsp_load   = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    ctl.op        = ffa_pkg::OP_HOLD;
    ctl.run       = run;
    ctl.new_limit = endv[31:0];
    ctl.count     = count;
    ctl.rem_idx   = fidx;
    if (state == S_SCAN) begin
      ctl.op = ffa_pkg::OP_ROT;
    end else if (state == S_UPD) begin
      if (func == ffa_pkg::FUNC_ALLOC) begin
        if (alloc_ok) ctl.op = ffa_pkg::OP_INS;
      end else begin
        ctl.op = ffa_pkg::OP_REM;
      end
    end
  end

  for (genvar i = 0; i < ffa_pkg::MAX_BLOCKS; i++) begin : g_cell
    ffa_cell u_cell (
      .clk     (clk),
      .index   (ffa_pkg::IDX_W'(i)),
      .ctl     (ctl),
      .left    ((i == 0) ? '0 : entries[(i + ffa_pkg::MAX_BLOCKS - 1) % ffa_pkg::MAX_BLOCKS]),
      .left_le ((i == 0) ? 1'b1 : les[(i + ffa_pkg::MAX_BLOCKS - 1) % ffa_pkg::MAX_BLOCKS]),
      .right   (entries[(i + 1) % ffa_pkg::MAX_BLOCKS]),
      .entry   (entries[i]),
      .le      (les[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      brk       <= '0;
      heap_base <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            heap_base <= cfg_data;
            brk       <= cfg_data;
            count     <= '0;
          end else if (req_valid) begin
            func    <= req.func;
            size    <= req.request_size;
            addr    <= req.block_address;
            run     <= heap_base;
            top     <= heap_base;
            placed  <= 1'b0;
            found   <= 1'b0;
            fidx    <= '0;
            k       <= '0;
            if (req.func == ffa_pkg::FUNC_ALLOC &&
                count == ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS)) begin
              status <= ffa_pkg::ST_FULL;
              result <= '0;
              state  <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (head_valid) begin
            if (func == ffa_pkg::FUNC_ALLOC) begin
              if (!placed) begin
                if (head.base >= run && (head.base - run) >= {7'd0, size}) placed <= 1'b1;
                else run <= head.limit;
              end
            end else begin
              if (!found && head.base == addr) begin
                found <= 1'b1;
                fidx  <= k;
              end else if (head.limit > top) begin
                top <= head.limit;
              end
            end
          end
          if (k == ffa_pkg::IDX_W'(ffa_pkg::MAX_BLOCKS - 1)) state <= S_CALC1;
          else k <= k + 1'b1;
        end
        S_CALC1: begin
          if (func == ffa_pkg::FUNC_ALLOC) begin
            endv  <= {1'b0, run} + {8'd0, size};
            state <= S_CALC2;
          end else if (!found) begin
            status <= ffa_pkg::ST_NOT_FOUND;
            result <= '0;
            state  <= S_DONE;
          end else begin
            endv  <= {1'b0, top - heap_base};
            state <= S_CALC2;
          end
        end
        S_CALC2: begin
          if (func == ffa_pkg::FUNC_ALLOC) begin
            grow_en <= !placed && (endv > {1'b0, brk});
            grow    <= ({1'b0, excess} + 34'(ffa_pkg::PAGE_BYTES - 1)) & PAGE_MASK;
          end else begin
            grow <= ({1'b0, endv} + 34'(ffa_pkg::PAGE_BYTES - 1)) & PAGE_MASK;
          end
          state <= S_CALC3;
        end
        S_CALC3: begin
          if (func == ffa_pkg::FUNC_ALLOC) calc <= grow_en ? {2'd0, brk} + grow : {2'd0, brk};
          else calc <= {2'd0, heap_base} + grow;
          state <= S_UPD;
        end
        S_UPD: begin
          if (func == ffa_pkg::FUNC_ALLOC) begin
            if (alloc_ok) begin
              brk    <= calc[31:0];
              count  <= count + 1'b1;
              status <= ffa_pkg::ST_OK;
              result <= run;
            end else begin
              status <= ffa_pkg::ST_FULL;
              result <= '0;
            end
          end else begin
            if (calc < {2'd0, brk}) brk <= calc[31:0];
            count  <= count - 1'b1;
            status <= ffa_pkg::ST_OK;
            result <= '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.status         <= status;
            rsp.result_address <= result;
            rsp.heap_top       <= brk;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/ffa_cell.sv
// One table entry of the sorted block chain: rotate, insert and remove shifts.
// Depends on ffa_pkg.
module ffa_cell (
  input  logic                     clk,
  input  logic [ffa_pkg::IDX_W-1:0] index,
  input  ffa_pkg::cell_ctl_t       ctl,
  input  ffa_pkg::entry_t          left,
  input  logic                     left_le,
  input  ffa_pkg::entry_t          right,
  output ffa_pkg::entry_t          entry,
  output logic                     le
);

  assign le = ({1'b0, index} < ctl.count) && (entry.base <= ctl.run);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      ffa_pkg::OP_ROT: entry <= right;
      ffa_pkg::OP_INS: begin
        if (!le) begin
          if (left_le) begin
            entry.base  <= ctl.run;
            entry.limit <= ctl.new_limit;
          end else begin
            entry <= left;
          end
        end
      end
      ffa_pkg::OP_REM: begin
        if (index >= ctl.rem_idx) entry <= right;
      end
      default: entry <= entry;
    endcase
  end

endmodule
